// ----- rtl/rrcs_pkg.sv -----
package rrcs_pkg;

	localparam int TEAM_W        = 4;
	localparam int POS_W         = 4;
	localparam int CNT_W         = 5;
	localparam int SLOT_W        = 5;
	localparam int MIDX_W        = 8;
	localparam int HALF_W        = CNT_W - 1;
	localparam int CFG_AW        = 1;
	localparam int CFG_DW        = 5;
	localparam int IN_DW         = 8;
	localparam int OUT_DW        = 24;
	localparam int MAX_TEAMS_DEF = 16;
	localparam int MIN_TEAMS     = 4;
	localparam int TC_RESET      = 16;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EMIT = 1'b1
	} opcode_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_TEAM_COUNT = 1'b0,
		REG_HOME_MODE  = 1'b1
	} cfg_reg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // write one array entry, restart slot count
		logic start;  // begin a slot walk
		logic pair;   // produce one match
		logic exh;    // produce the exhausted result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;   // output register can take a result this cycle
		logic last_pair;  // current pair is the last of the slot
		logic exh_now;    // all slots for the current team count are done
	} sts_t;

endpackage

// ----- rtl/rrcs_ctrl.sv -----
module rrcs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  rrcs_pkg::opcode_t opcode,
	output logic            s_tready,
	output rrcs_pkg::cmd_t  cmd,
	input  rrcs_pkg::sts_t  sts
);
	import rrcs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_EXH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   acc;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (opcode == OP_LOAD) begin
						cmd.load = 1'b1;
					end else if (sts.exh_now) begin
						state_d = ST_EXH;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.pair = 1'b1;
					if (sts.last_pair) state_d = ST_IDLE;
				end
			end
			ST_EXH: begin
				if (sts.out_free) begin
					cmd.exh = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.start, cmd.pair, cmd.exh}))
		else $error("more than one datapath command at once");

	a_slot_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pair && sts.last_pair) |=> (state_q == ST_IDLE))
		else $error("walk did not end after the last pair");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pair || cmd.exh) |-> sts.out_free)
		else $error("result pushed into a full output register");

endmodule

// ----- rtl/rrcs_dpath.sv -----
module rrcs_dpath #(
	parameter int MAX_TEAMS = rrcs_pkg::MAX_TEAMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rrcs_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [rrcs_pkg::CFG_DW-1:0]   cfg_wdata,
	input  logic [rrcs_pkg::POS_W-1:0]    position,
	input  logic [rrcs_pkg::TEAM_W-1:0]   team_id,
	input  rrcs_pkg::cmd_t                cmd,
	output rrcs_pkg::sts_t                sts,
	input  logic                          m_tready,
	output logic                          out_valid,
	output logic [rrcs_pkg::MIDX_W-1:0]   out_midx,
	output logic [rrcs_pkg::SLOT_W-1:0]   out_slot,
	output logic [rrcs_pkg::TEAM_W-1:0]   out_home,
	output logic [rrcs_pkg::TEAM_W-1:0]   out_away,
	output logic                          out_last,
	output logic                          out_exh
);
	import rrcs_pkg::*;

	localparam int AW = (MAX_TEAMS > 1) ? $clog2(MAX_TEAMS) : 1;

	logic [CNT_W-1:0]  team_count_q;
	logic              home_mode_q;
	logic [TEAM_W-1:0] arr_q [MAX_TEAMS];
	logic [SLOT_W-1:0] slot_q;
	logic [HALF_W-1:0] m_q;
	logic              out_valid_q;
	logic [MIDX_W-1:0] midx_q;
	logic [SLOT_W-1:0] slotn_q;
	logic [TEAM_W-1:0] home_q;
	logic [TEAM_W-1:0] away_q;
	logic              last_q;
	logic              exh_q;

	logic [CNT_W-1:0]  n;
	logic [CNT_W-1:0]  n_m1;
	logic [HALF_W-1:0] half;
	logic [CNT_W:0]    total;
	logic              swap;
	logic [AW-1:0]     ia;
	logic [AW-1:0]     ib;
	logic [AW-1:0]     iwrap;
	logic [TEAM_W-1:0] t1;
	logic [TEAM_W-1:0] t2;
	logic [TEAM_W-1:0] home;
	logic [TEAM_W-1:0] away;
	logic [MIDX_W:0]   prod;
	logic [MIDX_W:0]   adj;
	logic [MIDX_W:0]   midx_sum;
	logic              out_free;
	logic              last_pair;
	logic              pos_ok;

	// even team count, clamped to the supported range
	always_comb begin
		n = {team_count_q[CNT_W-1:1], 1'b0};
		if (n < CNT_W'(MIN_TEAMS)) n = CNT_W'(MIN_TEAMS);
		if (int'(n) > MAX_TEAMS) n = CNT_W'(MAX_TEAMS & ~1);
	end

	assign n_m1  = n - CNT_W'(1);
	assign half  = n[CNT_W-1:1];
	assign total = {n, 1'b0} - (CNT_W+1)'(2);
	assign swap  = home_mode_q ? slot_q[0] : (slot_q >= n_m1);

	assign ia    = AW'(m_q);
	assign ib    = AW'(n_m1 - CNT_W'(m_q));
	assign iwrap = AW'(n_m1);
	assign t1    = arr_q[ia];
	assign t2    = arr_q[ib];
	assign home  = swap ? t2 : t1;
	assign away  = swap ? t1 : t2;

	assign prod     = (MIDX_W+1)'(home) * (MIDX_W+1)'(n_m1);
	assign adj      = (away < home) ? (MIDX_W+1)'(away) : (MIDX_W+1)'(away) - (MIDX_W+1)'(1);
	assign midx_sum = prod + adj;

	assign last_pair = (m_q == half - HALF_W'(1));
	assign out_free  = !out_valid_q || m_tready;
	assign pos_ok    = int'(position) < MAX_TEAMS;

	assign sts.out_free  = out_free;
	assign sts.last_pair = last_pair;
	assign sts.exh_now   = ({1'b0, slot_q} >= total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			team_count_q <= CNT_W'(TC_RESET);
			home_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_TEAM_COUNT: team_count_q <= cfg_wdata[CNT_W-1:0];
				REG_HOME_MODE:  home_mode_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// rotation array: load one entry, or rotate 1..n-1 right after a slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TEAMS; i++) arr_q[i] <= TEAM_W'(i);
		end else if (cmd.load) begin
			if (pos_ok) arr_q[AW'(position)] <= team_id;
		end else if (cmd.pair && last_pair) begin
			for (int i = 1; i < MAX_TEAMS; i++) begin
				if (i == 1) arr_q[i] <= arr_q[iwrap];
				else if (i < int'(n)) arr_q[i] <= arr_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			m_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) slot_q <= '0;
			else if (cmd.pair && last_pair) slot_q <= slot_q + SLOT_W'(1);

			if (cmd.start) m_q <= '0;
			else if (cmd.pair) m_q <= m_q + HALF_W'(1);

			if (cmd.pair || cmd.exh) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pair) begin
			midx_q  <= midx_sum[MIDX_W-1:0];
			slotn_q <= slot_q + SLOT_W'(1);
			home_q  <= home;
			away_q  <= away;
			last_q  <= last_pair;
			exh_q   <= 1'b0;
		end else if (cmd.exh) begin
			midx_q  <= '0;
			slotn_q <= '0;
			home_q  <= '0;
			away_q  <= '0;
			last_q  <= 1'b0;
			exh_q   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_midx  = midx_q;
	assign out_slot  = slotn_q;
	assign out_home  = home_q;
	assign out_away  = away_q;
	assign out_last  = last_q;
	assign out_exh   = exh_q;

	a_pair_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pair |-> (m_q < half))
		else $error("pair counter beyond half the team count");

	a_slot_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pair && last_pair) |=> (slot_q == $past(slot_q) + SLOT_W'(1)))
		else $error("slot count did not advance after a slot");

	a_exh_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exh |=> ($stable(slot_q) && out_exh))
		else $error("exhausted result changed the slot count");

endmodule

// ----- rtl/round_robin_circle_scheduler_unit.sv -----
// Channel   Dir  tdata (low bit up)                           tuser     tlast
// s_axis    in   position[3:0], team_id[7:4]                  opcode    -
// m_axis    out  match_index[7:0], slot_number[12:8],         exhausted last_of_slot
//                home_team[16:13], away_team[20:17], 0 pad
// cfg       in   cfg_we / cfg_addr / cfg_wdata, write only
//
// A load item is written as it is accepted; the unit is then ready for more.
// An emit item yields the matches of one slot, or the exhausted result. The single
// pairing unit forms one match per cycle from the rotation array while the output is free.
// Reset restores the identity order, clears the slot count, team_count = 16,
// home_mode = 0. A stalled m_tready holds the walk; loads are still taken while
// the last result of a slot waits in the output register.
module round_robin_circle_scheduler_unit #(
	parameter int MAX_TEAMS = rrcs_pkg::MAX_TEAMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write port
	input  logic                        cfg_we,
	input  logic [rrcs_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [rrcs_pkg::CFG_DW-1:0] cfg_wdata,
	// input items
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [rrcs_pkg::IN_DW-1:0]  s_tdata,   // position[3:0], team_id[7:4]
	input  logic                        s_tuser,   // opcode
	// result items
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [rrcs_pkg::OUT_DW-1:0] m_tdata,   // match_index, slot_number, home, away
	output logic                        m_tuser,   // exhausted
	output logic                        m_tlast    // last_of_slot
);
	import rrcs_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic [MIDX_W-1:0] midx;
	logic [SLOT_W-1:0] slotn;
	logic [TEAM_W-1:0] home;
	logic [TEAM_W-1:0] away;

	// sequencer: accept, walk the pairs of one slot, or give the exhausted result
	rrcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.opcode   (opcode_t'(s_tuser)),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// rotation array, slot count, pairing unit and output register
	rrcs_dpath #(
		.MAX_TEAMS (MAX_TEAMS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.position  (s_tdata[POS_W-1:0]),
		.team_id   (s_tdata[POS_W+TEAM_W-1:POS_W]),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.out_valid (m_tvalid),
		.out_midx  (midx),
		.out_slot  (slotn),
		.out_home  (home),
		.out_away  (away),
		.out_last  (m_tlast),
		.out_exh   (m_tuser)
	);

	// pack fields from the low bit up, zero pad to whole bytes
	assign m_tdata = OUT_DW'({away, home, slotn, midx});

endmodule
